// File: hw/rtl/spi_flash_erase_program_planner_macros.svh
// assertion macros for the spi flash erase and program planner
`ifndef SPI_FLASH_ERASE_PROGRAM_PLANNER_MACROS_SVH
`define SPI_FLASH_ERASE_PROGRAM_PLANNER_MACROS_SVH

`ifndef SYNTHESIS
`define SFEPP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFEPP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SFEPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFEPP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// File: hw/rtl/sfepp_pkg.sv
// shared types and constants of the spi flash erase and program planner
package sfepp_pkg;

    localparam int OPC_W      = 3;
    localparam int START_W    = 25;
    localparam int AMT_W      = 26;
    localparam int ADDR_W     = 26;
    localparam int CMD_W      = 3;
    localparam int CMD_ADDR_W = 24;
    localparam int LEN_W      = 9;
    localparam int TMO_W      = 12;
    localparam int CAPC_W     = 3;
    localparam int PROT_W     = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    localparam logic [ADDR_W-1:0] BASE_CAPACITY = ADDR_W'(32'h0010_0000);
    localparam logic [CAPC_W-1:0] MAX_CAP_CODE  = CAPC_W'(5);

    localparam logic [OPC_W-1:0] OP_ERASE_CHK   = 3'd0;
    localparam logic [OPC_W-1:0] OP_ERASE_UNCHK = 3'd1;
    localparam logic [OPC_W-1:0] OP_WRITE_CHK   = 3'd2;
    localparam logic [OPC_W-1:0] OP_WRITE_UNCHK = 3'd3;
    localparam logic [OPC_W-1:0] OP_STEP_OK     = 3'd4;
    localparam logic [OPC_W-1:0] OP_STEP_FAIL   = 3'd5;

    localparam logic [CMD_W-1:0] CMD_NONE         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PAGE_PROGRAM = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE_SECTOR = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ERASE_SMALL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ERASE_LARGE  = 3'd4;

    localparam logic [TMO_W-1:0] TMO_LARGE  = 12'd3000;
    localparam logic [TMO_W-1:0] TMO_SMALL  = 12'd1600;
    localparam logic [TMO_W-1:0] TMO_SECTOR = 12'd400;
    localparam logic [TMO_W-1:0] TMO_PAGE   = 12'd100;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_CODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROTECTED_SECTORS = 1'b1;

    typedef enum logic [2:0] {
        REQ_NOP       = 3'd0,
        REQ_REJECT    = 3'd1,
        REQ_ERASE     = 3'd2,
        REQ_WRITE     = 3'd3,
        REQ_STEP_OK   = 3'd4,
        REQ_STEP_FAIL = 3'd5
    } t_req_kind;

    typedef struct packed {
        t_req_kind         kind;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
    } t_plan_req;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd_kind;
        logic [CMD_ADDR_W-1:0] cmd_address;
        logic [LEN_W-1:0]      program_length;
        logic [TMO_W-1:0]      timeout_ms;
        logic                  finished;
        logic                  succeeded;
    } t_rsp;

endpackage

// File: hw/rtl/sfepp_req_if.sv
// request channel interface
interface sfepp_req_if;
    logic                         valid;
    logic                         ready;
    logic [sfepp_pkg::OPC_W-1:0]   opcode;
    logic [sfepp_pkg::START_W-1:0] start_address;
    logic [sfepp_pkg::AMT_W-1:0]   amount;

    modport source(output valid, output opcode, output start_address, output amount,
                   input ready);
    modport sink(input valid, input opcode, input start_address, input amount,
                 output ready);
endinterface

// File: hw/rtl/sfepp_rsp_if.sv
// command result channel interface
interface sfepp_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sfepp_pkg::CMD_W-1:0]      cmd_kind;
    logic [sfepp_pkg::CMD_ADDR_W-1:0] cmd_address;
    logic [sfepp_pkg::LEN_W-1:0]      program_length;
    logic [sfepp_pkg::TMO_W-1:0]      timeout_ms;
    logic                            finished;
    logic                            succeeded;

    modport source(output valid, output cmd_kind, output cmd_address,
                   output program_length, output timeout_ms, output finished,
                   output succeeded, input ready);
    modport sink(input valid, input cmd_kind, input cmd_address,
                 input program_length, input timeout_ms, input finished,
                 input succeeded, output ready);
endinterface

// File: hw/rtl/sfepp_cfg_if.sv
// configuration write channel interface
interface sfepp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sfepp_pkg::CFG_IDX_W-1:0]     index;
    logic [sfepp_pkg::CFG_DATA_W-1:0]    data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/sfepp_front.sv
// front end: configuration registers, request decode and range checks
module sfepp_front #(
    parameter int SECTOR_BYTES = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sfepp_req_if.sink            i_req,
    sfepp_cfg_if.sink            i_cfg,
    input  logic                 i_full,
    output logic                 o_push,
    output sfepp_pkg::t_plan_req o_push_data
);

    localparam int SECTOR_SH = $clog2(SECTOR_BYTES);
    localparam int XW        = sfepp_pkg::AMT_W + SECTOR_SH + 1;

    logic [sfepp_pkg::CAPC_W-1:0] r_cap_code;
    logic [sfepp_pkg::PROT_W-1:0] r_prot_sectors;

    logic [sfepp_pkg::CAPC_W-1:0] cap_eff;
    logic [sfepp_pkg::ADDR_W-1:0] cap;
    logic [XW-1:0]                cap_x;
    logic [XW-1:0]                start_x;
    logic [XW-1:0]                prot_x;
    logic [XW-1:0]                first_e;
    logic [XW-1:0]                last_e;
    logic [XW-1:0]                last_w;
    logic                         checked;
    logic                         is_write;
    logic                         reject;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_code     <= '0;
            r_prot_sectors <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sfepp_pkg::REG_CAPACITY_CODE: begin
                    r_cap_code <= i_cfg.data[sfepp_pkg::CAPC_W-1:0];
                end
                sfepp_pkg::REG_PROTECTED_SECTORS: begin
                    r_prot_sectors <= i_cfg.data[sfepp_pkg::PROT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cap_eff = (r_cap_code > sfepp_pkg::MAX_CAP_CODE) ? sfepp_pkg::MAX_CAP_CODE
                                                              : r_cap_code;
    assign cap     = sfepp_pkg::BASE_CAPACITY << cap_eff;
    assign cap_x   = XW'(cap);
    assign start_x = XW'(i_req.start_address);
    assign prot_x  = XW'(r_prot_sectors) << SECTOR_SH;
    assign first_e = (start_x >> SECTOR_SH) << SECTOR_SH;
    assign last_e  = first_e + (XW'(i_req.amount) << SECTOR_SH);
    assign last_w  = start_x + XW'(i_req.amount);

    assign checked  = (i_req.opcode == sfepp_pkg::OP_ERASE_CHK) ||
                      (i_req.opcode == sfepp_pkg::OP_WRITE_CHK);
    assign is_write = (i_req.opcode == sfepp_pkg::OP_WRITE_CHK) ||
                      (i_req.opcode == sfepp_pkg::OP_WRITE_UNCHK);

    always_comb begin
        reject = 1'b0;
        if (i_req.amount == '0) begin
            reject = 1'b1;
        end
        if (checked && ((start_x < prot_x) || (start_x >= cap_x))) begin
            reject = 1'b1;
        end
        if (is_write ? (last_w >= cap_x) : (last_e > cap_x)) begin
            reject = 1'b1;
        end
    end

    always_comb begin
        o_push_data.first = sfepp_pkg::ADDR_W'(is_write ? start_x : first_e);
        o_push_data.last  = sfepp_pkg::ADDR_W'(is_write ? last_w : last_e);
        case (i_req.opcode) inside
            sfepp_pkg::OP_ERASE_CHK, sfepp_pkg::OP_ERASE_UNCHK,
            sfepp_pkg::OP_WRITE_CHK, sfepp_pkg::OP_WRITE_UNCHK: begin
                if (reject) begin
                    o_push_data.kind = sfepp_pkg::REQ_REJECT;
                end else if (is_write) begin
                    o_push_data.kind = sfepp_pkg::REQ_WRITE;
                end else begin
                    o_push_data.kind = sfepp_pkg::REQ_ERASE;
                end
            end
            sfepp_pkg::OP_STEP_OK: begin
                o_push_data.kind = sfepp_pkg::REQ_STEP_OK;
            end
            sfepp_pkg::OP_STEP_FAIL: begin
                o_push_data.kind = sfepp_pkg::REQ_STEP_FAIL;
            end
            default: begin
                o_push_data.kind = sfepp_pkg::REQ_NOP;
            end
        endcase
    end

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

endmodule

// File: hw/rtl/sfepp_queue.sv
// two entry queue between request decode and the command sequencer
module sfepp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sfepp_pkg::t_plan_req i_push_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_head_valid,
    output sfepp_pkg::t_plan_req o_head
);

`include "spi_flash_erase_program_planner_macros.svh"

    localparam logic [1:0] QD = 2'd2;

    sfepp_pkg::t_plan_req r_mem [2];
    logic                 r_head;
    logic                 r_tail;
    logic [1:0]           r_count;
    logic [1:0]           n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= !r_tail;
            end
            if (i_pop) begin
                r_head <= !r_head;
            end
            r_count <= n_count;
        end
    end

    assign o_full       = (r_count == QD);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_head];

    `SFEPP_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && (r_count == QD), "push into full queue")
    `SFEPP_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && (r_count == 2'd0), "pop from empty queue")

endmodule

// File: hw/rtl/sfepp_back.sv
// back end: plan state, command selection and result register
module sfepp_back #(
    parameter int PAGE_BYTES        = 256,
    parameter int SECTOR_BYTES      = 4096,
    parameter int SMALL_BLOCK_BYTES = 32768,
    parameter int LARGE_BLOCK_BYTES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  sfepp_pkg::t_plan_req i_head,
    output logic                 o_pop,
    sfepp_rsp_if.source          o_rsp
);

`include "spi_flash_erase_program_planner_macros.svh"

    localparam int AW        = sfepp_pkg::ADDR_W;
    localparam int PAGE_SH   = $clog2(PAGE_BYTES);
    localparam int SECTOR_SH = $clog2(SECTOR_BYTES);
    localparam int SMALL_SH  = $clog2(SMALL_BLOCK_BYTES);
    localparam int LARGE_SH  = $clog2(LARGE_BLOCK_BYTES);
    localparam int STEP_W    = $clog2(LARGE_BLOCK_BYTES + 1);

    logic                r_busy;
    logic                r_write;
    logic [AW-1:0]       r_cur;
    logic [AW-1:0]       r_end;
    logic [STEP_W-1:0]   r_pend;
    logic                r_out_valid;
    sfepp_pkg::t_rsp     r_out;

    logic                n_busy;
    logic                n_write;
    logic [AW-1:0]       n_cur;
    logic [AW-1:0]       n_end;
    logic [STEP_W-1:0]   n_pend;
    sfepp_pkg::t_rsp     n_out;

    logic                do_issue;
    logic                sel_write;
    logic [AW-1:0]       sel_cur;
    logic [AW-1:0]       sel_end;
    logic [AW-1:0]       next_cur;
    logic [AW-1:0]       left;
    logic [PAGE_SH:0]    pg_room;
    logic [PAGE_SH:0]    chunk;
    sfepp_pkg::t_rsp     iss_out;
    logic [STEP_W-1:0]   iss_step;

    assign o_pop    = i_head_valid && (!r_out_valid || o_rsp.ready);
    assign next_cur = r_cur + AW'(r_pend);

    // command choice for the address pair picked below
    assign left    = sel_end - sel_cur;
    assign pg_room = (PAGE_SH + 1)'(PAGE_BYTES) - {1'b0, sel_cur[PAGE_SH-1:0]};
    assign chunk   = (AW'(pg_room) > left) ? left[PAGE_SH:0] : pg_room;

    always_comb begin
        iss_out             = '0;
        iss_out.cmd_address = sel_cur[sfepp_pkg::CMD_ADDR_W-1:0];
        if (sel_write) begin
            iss_step               = STEP_W'(chunk);
            iss_out.cmd_kind       = sfepp_pkg::CMD_PAGE_PROGRAM;
            iss_out.program_length = sfepp_pkg::LEN_W'(chunk);
            iss_out.timeout_ms     = sfepp_pkg::TMO_PAGE;
        end else if ((left >= AW'(LARGE_BLOCK_BYTES)) && (sel_cur[LARGE_SH-1:0] == '0)) begin
            iss_step           = STEP_W'(LARGE_BLOCK_BYTES);
            iss_out.cmd_kind   = sfepp_pkg::CMD_ERASE_LARGE;
            iss_out.timeout_ms = sfepp_pkg::TMO_LARGE;
        end else if ((left >= AW'(SMALL_BLOCK_BYTES)) && (sel_cur[SMALL_SH-1:0] == '0)) begin
            iss_step           = STEP_W'(SMALL_BLOCK_BYTES);
            iss_out.cmd_kind   = sfepp_pkg::CMD_ERASE_SMALL;
            iss_out.timeout_ms = sfepp_pkg::TMO_SMALL;
        end else begin
            iss_step           = STEP_W'(SECTOR_BYTES);
            iss_out.cmd_kind   = sfepp_pkg::CMD_ERASE_SECTOR;
            iss_out.timeout_ms = sfepp_pkg::TMO_SECTOR;
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_write   = r_write;
        n_cur     = r_cur;
        n_end     = r_end;
        n_pend    = r_pend;
        n_out     = '0;
        do_issue  = 1'b0;
        sel_write = r_write;
        sel_cur   = next_cur;
        sel_end   = r_end;
        case (i_head.kind)
            sfepp_pkg::REQ_REJECT: begin
                n_busy         = 1'b0;
                n_out.finished = 1'b1;
            end
            sfepp_pkg::REQ_ERASE, sfepp_pkg::REQ_WRITE: begin
                n_busy    = 1'b1;
                n_write   = (i_head.kind == sfepp_pkg::REQ_WRITE);
                sel_write = (i_head.kind == sfepp_pkg::REQ_WRITE);
                sel_cur   = i_head.first;
                sel_end   = i_head.last;
                do_issue  = 1'b1;
            end
            sfepp_pkg::REQ_STEP_OK: begin
                if (r_busy) begin
                    if (next_cur >= r_end) begin
                        n_busy          = 1'b0;
                        n_out.finished  = 1'b1;
                        n_out.succeeded = 1'b1;
                    end else begin
                        do_issue = 1'b1;
                    end
                end
            end
            sfepp_pkg::REQ_STEP_FAIL: begin
                if (r_busy) begin
                    n_busy         = 1'b0;
                    n_out.finished = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (do_issue) begin
            n_cur  = sel_cur;
            n_end  = sel_end;
            n_pend = iss_step;
            n_out  = iss_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_write     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy      <= n_busy;
                r_write     <= n_write;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= n_cur;
            r_end  <= n_end;
            r_pend <= n_pend;
            r_out  <= n_out;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.cmd_kind       = r_out.cmd_kind;
    assign o_rsp.cmd_address    = r_out.cmd_address;
    assign o_rsp.program_length = r_out.program_length;
    assign o_rsp.timeout_ms     = r_out.timeout_ms;
    assign o_rsp.finished       = r_out.finished;
    assign o_rsp.succeeded      = r_out.succeeded;

    `SFEPP_ASSERT(a_busy_in_range, i_clk, i_rst_n, r_busy |-> (r_cur < r_end), "plan address at or past end")
    `SFEPP_ASSERT(a_erase_aligned, i_clk, i_rst_n, (r_busy && !r_write) |-> (r_cur[SECTOR_SH-1:0] == '0), "erase address not sector aligned")
    `SFEPP_ASSERT_NEVER(a_fin_no_cmd, i_clk, i_rst_n, r_out_valid && r_out.finished && (r_out.cmd_kind != sfepp_pkg::CMD_NONE), "finished result carries a command")

endmodule

// File: hw/rtl/spi_flash_erase_program_planner.sv
// top level of the spi flash erase and program planner
//
// i_req takes erase or write requests and step reports (ok or failed) for
// the command last issued. every accepted request gives exactly one result
// on o_rsp: the next flash command with its address, page program length
// and busy timeout, or a finished flag with the success bit.
// i_cfg writes the capacity code and the protected sector count; write it
// only while no request is in flight.
// a request accepted on i_req passes through a queue entry and then the
// result register before its result shows on o_rsp.
// one request per cycle is taken and one result per cycle is given while
// o_rsp.ready is high; one request a cycle is the sequencer's limit.
// a two entry queue sits between the decode and the sequencer and a result
// register drives o_rsp: when the receiver holds ready low the result waits
// in the register, the queue fills and then i_req.ready drops.
// reset empties the queue, drops any running plan and clears both config
// registers; the block takes requests in the first cycle after reset.
module spi_flash_erase_program_planner #(
    parameter int PAGE_BYTES        = 256,
    parameter int SECTOR_BYTES      = 4096,
    parameter int SMALL_BLOCK_BYTES = 32768,
    parameter int LARGE_BLOCK_BYTES = 65536
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sfepp_req_if.sink    i_req,
    sfepp_cfg_if.sink    i_cfg,
    sfepp_rsp_if.source  o_rsp
);

    logic                 q_full;
    logic                 q_push;
    sfepp_pkg::t_plan_req q_push_data;
    logic                 q_pop;
    logic                 q_head_valid;
    sfepp_pkg::t_plan_req q_head;

    sfepp_front #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (i_cfg),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    sfepp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_data  (q_push_data),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    sfepp_back #(
        .PAGE_BYTES        (PAGE_BYTES),
        .SECTOR_BYTES      (SECTOR_BYTES),
        .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES),
        .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_rsp        (o_rsp)
    );

endmodule
